[hw/rtl/tcu_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// tcu_pkg: shared types and constants of the three-channel timer/counter unit
// Request and response words, control-word bit positions, request codes and
// the word exchanged between the top level and the timer service logic.
// ----------------------------------------------------------------------------
package tcu_pkg;

    // Count and compare register width
    localparam int COUNT_WIDTH = 16;
    localparam int NUM_TIMERS  = 3;

    typedef logic [COUNT_WIDTH-1:0] cnt_t;
    typedef logic [1:0]             tidx_t;

    // Control word bit positions
    localparam int CT_EN   = 15;
    localparam int CT_INH  = 14;
    localparam int CT_INT  = 13;
    localparam int CT_RIU  = 12;
    localparam int CT_MC   = 5;
    localparam int CT_RTG  = 4;
    localparam int CT_P    = 3;
    localparam int CT_EXT  = 2;
    localparam int CT_ALT  = 1;
    localparam int CT_CONT = 0;

    // Request codes
    typedef enum logic [2:0] {
        REQ_TICK   = 3'd0,
        REQ_READ   = 3'd1,
        REQ_WRITE  = 3'd2,
        REQ_PIN    = 3'd3,
        REQ_SRESET = 3'd4
    } req_code_t;

    // Register select codes
    typedef enum logic [1:0] {
        SEL_CTRL  = 2'd0,
        SEL_COUNT = 2'd1,
        SEL_MAXA  = 2'd2,
        SEL_MAXB  = 2'd3
    } sel_code_t;

    // Tick phase that services no timer, and the timer whose max-count match prescales
    localparam tidx_t PHASE_IDLE     = 2'd3;
    localparam tidx_t TIMER_PRESCALE = 2'd2;

    typedef struct packed {
        logic [2:0]  req_type;
        logic [1:0]  timer_index;
        logic [1:0]  reg_select;
        logic [15:0] write_data;
        logic        pin_level;
    } tcu_req_t;

    typedef struct packed {
        logic [15:0] read_data;
        logic [2:0]  out_levels;
        logic [2:0]  out_pulse;
        logic [2:0]  int_levels;
        logic [2:0]  int_event;
    } tcu_rsp_t;

    // Timer state handed to the service logic
    typedef struct packed {
        logic [15:0] ctl;
        cnt_t        count;
        cnt_t        max_a;
        cnt_t        max_b;
        logic        pin_was;
        logic        pin_now;
        logic        out_level;
        logic        prescale;
    } tcu_svc_in_t;

    // Updated timer state from the service logic
    typedef struct packed {
        logic [15:0] ctl;
        cnt_t        count;
        logic        out_level;
        logic        max_reached;
        logic        pulse;
        logic        irq;
    } tcu_svc_out_t;

    // Fit a 16-bit bus word to the count width
    function automatic cnt_t to_cnt(input logic [15:0] d);
        logic [31:0] tmp;
        tmp = 32'(d);
        return tmp[COUNT_WIDTH-1:0];
    endfunction

    // Low 16 bits of a count-width register
    function automatic logic [15:0] to_word(input cnt_t c);
        logic [31:0] tmp;
        tmp = 32'(c);
        return tmp[15:0];
    endfunction

endpackage
`default_nettype wire

[hw/rtl/tcu_service.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// tcu_service: one tick of service for the selected timer
// Gates the count by enable, external edge, retrigger, level and prescale,
// increments, compares against max count A or alternates A and B, and
// produces the new control word, count, output level and interrupt request.
// ----------------------------------------------------------------------------
module tcu_service (
    input  wire tcu_pkg::tcu_svc_in_t  svc_in,
    output      tcu_pkg::tcu_svc_out_t svc_out
);
    import tcu_pkg::*;

    logic rise;
    logic advance;
    logic restart;
    logic hit;
    cnt_t count_inc;

    always_comb
    begin
        rise      = !svc_in.pin_was && svc_in.pin_now;
        count_inc = svc_in.count + cnt_t'(1);
        advance   = 1'b0;
        restart   = 1'b0;
        hit       = 1'b0;

        svc_out             = '0;
        svc_out.ctl         = svc_in.ctl;
        svc_out.count       = svc_in.count;
        svc_out.out_level   = svc_in.out_level;

        // gate the count
        if (svc_in.ctl[CT_EN])
        begin
            if (svc_in.ctl[CT_EXT])
                advance = rise;
            else if (svc_in.ctl[CT_RTG] && rise)
                restart = 1'b1;
            else if (!svc_in.ctl[CT_RTG] && !svc_in.pin_now)
                advance = 1'b0;
            else
                advance = !svc_in.ctl[CT_P] || svc_in.prescale;
        end

        if (restart)
            svc_out.count = '0;

        // advance and compare
        if (advance)
        begin
            svc_out.count = count_inc;
            if (svc_in.ctl[CT_ALT])
            begin
                if (svc_in.ctl[CT_RIU])
                begin
                    hit = (count_inc == svc_in.max_b);
                    if (hit)
                    begin
                        svc_out.ctl[CT_RIU] = 1'b0;
                        svc_out.out_level   = 1'b1;
                        if (!svc_in.ctl[CT_CONT])
                            svc_out.ctl[CT_EN] = 1'b0;
                    end
                end
                else
                begin
                    hit = (count_inc == svc_in.max_a);
                    if (hit)
                    begin
                        svc_out.ctl[CT_RIU] = 1'b1;
                        svc_out.out_level   = 1'b0;
                    end
                end
            end
            else
            begin
                hit = (count_inc == svc_in.max_a);
                if (hit)
                begin
                    svc_out.pulse     = svc_in.out_level;
                    svc_out.out_level = 1'b1;
                    if (!svc_in.ctl[CT_CONT])
                        svc_out.ctl[CT_EN] = 1'b0;
                end
            end
        end

        // finish a match
        if (hit)
        begin
            svc_out.count       = '0;
            svc_out.ctl[CT_MC]  = 1'b1;
            svc_out.max_reached = 1'b1;
            svc_out.irq         = svc_in.ctl[CT_INT];
        end
    end

endmodule
`default_nettype wire

[hw/rtl/three_channel_timer_counter_unit_top.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// three_channel_timer_counter_unit_top: three 16-bit timers with dual compare
//
//   channel | signals                 | word
//   --------+-------------------------+--------------------------------------
//   request | req_valid, req_ready    | req: type, timer, register, data, pin
//   response| rsp_valid, rsp_ready    | rsp: read data, pin and irq levels
//
// One word a cycle; a request passes the input register, then the service
// and register logic into the response register. Reset clears all timer
// state and the tick phase. A stalled response holds the pipeline; an empty
// input register still fills.
// ----------------------------------------------------------------------------
module three_channel_timer_counter_unit_top (
    input  wire  clk,
    input  wire  rst_n,
    input  wire  req_valid,
    output logic req_ready,
    input  wire  tcu_pkg::tcu_req_t req,
    output logic rsp_valid,
    input  wire  rsp_ready,
    output       tcu_pkg::tcu_rsp_t rsp
);
    import tcu_pkg::*;

    // Input stage
    logic     s1_valid_reg;
    tcu_req_t s1_reg;
    logic     advance;

    // Timer state
    logic [15:0] ctl_reg    [NUM_TIMERS];
    cnt_t        count_reg  [NUM_TIMERS];
    cnt_t        maxa_reg   [NUM_TIMERS];
    cnt_t        maxb_reg   [NUM_TIMERS];
    logic [15:0] ctl_next   [NUM_TIMERS];
    cnt_t        count_next [NUM_TIMERS];
    cnt_t        maxa_next  [NUM_TIMERS];
    cnt_t        maxb_next  [NUM_TIMERS];
    logic [NUM_TIMERS-1:0] pin_cur_reg, pin_cur_next;
    logic [NUM_TIMERS-1:0] pin_prev_reg, pin_prev_next;
    logic [NUM_TIMERS-1:0] mr_reg, mr_next;
    logic [NUM_TIMERS-1:0] ol_reg, ol_next;
    logic [NUM_TIMERS-1:0] il_reg, il_next;
    tidx_t phase_reg, phase_next;

    // Response stage
    logic     rsp_valid_reg;
    tcu_rsp_t rsp_reg, rsp_next;

    tcu_svc_in_t  svc_in;
    tcu_svc_out_t svc_out;

    logic [15:0] ctl_wr;
    logic [15:0] rd_word;
    logic [2:0]  pulse_bits;
    logic [2:0]  event_bits;

    // Move forward when the response register is free or being emptied
    assign advance   = !rsp_valid_reg || rsp_ready;
    assign req_ready = !s1_valid_reg || advance;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // Select the timer of the current tick phase
    always_comb
    begin
        svc_in          = '0;
        svc_in.prescale = (phase_reg != TIMER_PRESCALE) ? mr_reg[TIMER_PRESCALE] : 1'b0;
        for (int i = 0; i < NUM_TIMERS; i++)
        begin
            if (phase_reg == tidx_t'(i))
            begin
                svc_in.ctl       = ctl_reg[i];
                svc_in.count     = count_reg[i];
                svc_in.max_a     = maxa_reg[i];
                svc_in.max_b     = maxb_reg[i];
                svc_in.pin_was   = pin_prev_reg[i];
                svc_in.pin_now   = pin_cur_reg[i];
                svc_in.out_level = ol_reg[i];
            end
        end
    end

    tcu_service u_service (
        .svc_in  (svc_in),
        .svc_out (svc_out)
    );

    // Work out the next state and the response for the word in the input stage
    always_comb
    begin
        for (int i = 0; i < NUM_TIMERS; i++)
        begin
            ctl_next[i]   = ctl_reg[i];
            count_next[i] = count_reg[i];
            maxa_next[i]  = maxa_reg[i];
            maxb_next[i]  = maxb_reg[i];
        end
        pin_cur_next  = pin_cur_reg;
        pin_prev_next = pin_prev_reg;
        mr_next       = mr_reg;
        ol_next       = ol_reg;
        il_next       = il_reg;
        phase_next    = phase_reg;
        rd_word       = '0;
        pulse_bits    = '0;
        event_bits    = '0;
        ctl_wr        = s1_reg.write_data;

        // control writes keep EN unless INH is set, and always keep RIU
        for (int i = 0; i < NUM_TIMERS; i++)
        begin
            if (s1_reg.timer_index == tidx_t'(i))
            begin
                if (!s1_reg.write_data[CT_INH])
                    ctl_wr[CT_EN] = ctl_reg[i][CT_EN];
                ctl_wr[CT_RIU] = ctl_reg[i][CT_RIU];
            end
        end

        unique case (s1_reg.req_type)
            REQ_TICK:
            begin
                phase_next = phase_reg + tidx_t'(1);
                for (int i = 0; i < NUM_TIMERS; i++)
                begin
                    if (phase_reg == tidx_t'(i))
                    begin
                        pin_prev_next[i] = pin_cur_reg[i];
                        mr_next[i]       = svc_out.max_reached;
                        ctl_next[i]      = svc_out.ctl;
                        count_next[i]    = svc_out.count;
                        ol_next[i]       = svc_out.out_level;
                        pulse_bits[i]    = svc_out.pulse;
                        event_bits[i]    = svc_out.irq;
                        if (svc_out.irq)
                            il_next[i] = 1'b1;
                    end
                end
            end
            REQ_READ:
            begin
                for (int i = 0; i < NUM_TIMERS; i++)
                begin
                    if (s1_reg.timer_index == tidx_t'(i))
                    begin
                        unique case (s1_reg.reg_select)
                            SEL_CTRL:  rd_word = ctl_reg[i];
                            SEL_COUNT: rd_word = to_word(count_reg[i]);
                            SEL_MAXA:  rd_word = to_word(maxa_reg[i]);
                            SEL_MAXB:  rd_word = to_word(maxb_reg[i]);
                        endcase
                    end
                end
            end
            REQ_WRITE:
            begin
                for (int i = 0; i < NUM_TIMERS; i++)
                begin
                    if (s1_reg.timer_index == tidx_t'(i))
                    begin
                        unique case (s1_reg.reg_select)
                            SEL_CTRL:  ctl_next[i]   = ctl_wr;
                            SEL_COUNT: count_next[i] = to_cnt(s1_reg.write_data);
                            SEL_MAXA:  maxa_next[i]  = to_cnt(s1_reg.write_data);
                            SEL_MAXB:  maxb_next[i]  = to_cnt(s1_reg.write_data);
                        endcase
                    end
                end
            end
            REQ_PIN:
            begin
                for (int i = 0; i < NUM_TIMERS; i++)
                begin
                    if (s1_reg.timer_index == tidx_t'(i))
                        pin_cur_next[i] = s1_reg.pin_level;
                end
            end
            REQ_SRESET:
            begin
                for (int i = 0; i < NUM_TIMERS; i++)
                begin
                    ctl_next[i]   = '0;
                    count_next[i] = '0;
                    maxa_next[i]  = '0;
                    maxb_next[i]  = '0;
                end
                mr_next = '0;
            end
            default:
            begin
                rd_word = '0;
            end
        endcase

        rsp_next.read_data  = rd_word;
        rsp_next.out_levels = ol_next;
        rsp_next.out_pulse  = pulse_bits;
        rsp_next.int_levels = il_next;
        rsp_next.int_event  = event_bits;
    end

    // Input stage: take a new word whenever the stage empties or moves on
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (req_ready)
            s1_valid_reg <= req_valid;
    end

    always_ff @(posedge clk)
    begin
        if (req_ready && req_valid)
            s1_reg <= req;
    end

    // Timer state and response valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_TIMERS; i++)
            begin
                ctl_reg[i]   <= '0;
                count_reg[i] <= '0;
                maxa_reg[i]  <= '0;
                maxb_reg[i]  <= '0;
            end
            pin_cur_reg   <= '0;
            pin_prev_reg  <= '0;
            mr_reg        <= '0;
            ol_reg        <= '0;
            il_reg        <= '0;
            phase_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            rsp_valid_reg <= s1_valid_reg;
            if (s1_valid_reg)
            begin
                for (int i = 0; i < NUM_TIMERS; i++)
                begin
                    ctl_reg[i]   <= ctl_next[i];
                    count_reg[i] <= count_next[i];
                    maxa_reg[i]  <= maxa_next[i];
                    maxb_reg[i]  <= maxb_next[i];
                end
                pin_cur_reg  <= pin_cur_next;
                pin_prev_reg <= pin_prev_next;
                mr_reg       <= mr_next;
                ol_reg       <= ol_next;
                il_reg       <= il_next;
                phase_reg    <= phase_next;
            end
        end
    end

    // Response word
    always_ff @(posedge clk)
    begin
        if (advance && s1_valid_reg)
            rsp_reg <= rsp_next;
    end

endmodule
`default_nettype wire

[hw/rtl/tcu_checker.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// tcu_checker: port-level checks of the timer/counter unit
// Watches the response channel for pulse and interrupt consistency, falling
// interrupt lines, stall hold and non-tick events; bound to the top level.
// ----------------------------------------------------------------------------
module tcu_checker (
    input wire clk,
    input wire rst_n,
    input wire req_valid,
    input wire req_ready,
    input wire tcu_pkg::tcu_req_t req,
    input wire rsp_valid,
    input wire rsp_ready,
    input wire tcu_pkg::tcu_rsp_t rsp
);
    import tcu_pkg::*;

    logic [2:0] last_int_reg;
    logic       req_seen;

    assign req_seen = req_valid && req_ready && (req.req_type != REQ_TICK);

    // Hold the interrupt levels of the last delivered word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            last_int_reg <= '0;
        else if (rsp_valid && rsp_ready)
            last_int_reg <= rsp.int_levels;
    end

    // A pulse ends with the output pin high
    a_pulse_level: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> ((rsp.out_pulse & ~rsp.out_levels) == 3'b000))
        else $error("pulse reported on a low output pin");

    // A new interrupt leaves its line high
    a_event_level: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> ((rsp.int_event & ~rsp.int_levels) == 3'b000))
        else $error("interrupt event without raised line");

    // Interrupt lines never fall
    a_int_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> ((rsp.int_levels & last_int_reg) == last_int_reg))
        else $error("interrupt line lowered");

    // A stalled response holds
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp)))
        else $error("stalled response changed");

    // Only a tick can raise an event or a pulse: a non-tick word taken into an
    // idle response side shows once the word ahead has drained
    a_event_tick: assert property (@(posedge clk) disable iff (!rst_n)
        (req_seen && !rsp_valid) ##1 rsp_ready ##1 rsp_valid |->
            (rsp.int_event == 3'b000 && rsp.out_pulse == 3'b000))
        else $error("event from a non-tick word");

endmodule

bind three_channel_timer_counter_unit_top tcu_checker u_tcu_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
);
`default_nettype wire
